/* rtl/segment_reorder_receiver_core_defines.svh */
// assertion macros for the segment reorder receiver
// used by modules that carry concurrent checks; expects clk_i and rst_ni in scope
`ifndef SEGMENT_REORDER_RECEIVER_CORE_DEFINES_SVH
`define SEGMENT_REORDER_RECEIVER_CORE_DEFINES_SVH

// property checked at every clock edge outside reset
`define SRR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define SRR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/srr_pkg.sv */
// shared types and constants for the segment reorder receiver
// no dependencies
package srr_pkg;

  localparam int WindowSlotsDefault = 16;

  // result kinds
  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_DLV   = 2'd1;
  localparam logic [1:0] KIND_FIN   = 2'd2;
  localparam logic [1:0] KIND_CLOSE = 2'd3;

  // connection modes
  localparam logic [1:0] MODE_ESTABLISHED = 2'd0;
  localparam logic [1:0] MODE_CLOSE_WAIT  = 2'd1;
  localparam logic [1:0] MODE_LAST_ACK    = 2'd2;
  localparam logic [1:0] MODE_CLOSED      = 2'd3;

  // request to the shared adder: sum = a +/- b, eq = (sum == c)
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic        sub;
  } alu_req_t;

endpackage

/* rtl/segment_reorder_receiver_core.sv */
// an item goes through DIFF, STORE, FCHK, then ACK loads the first result (the ack),
// DLV loads each delivery and FIN the fin if one is sent; a dropped segment ends
// after DIFF, a close goes DIFF then CLOSE; all steps share one adder; output stalls
// hold ACK, DLV, FIN, CLOSE; one delivery per cycle while draining the in-order run
// reset: sequencer idle, window empty, expected sequence 0, established; the handle
// memory is left uninitialized and is only read behind a set valid bit
`include "segment_reorder_receiver_core_defines.svh"
module segment_reorder_receiver_core import srr_pkg::*; #(
  parameter int WINDOW_SLOTS = WindowSlotsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // seq_num[31:0], src_port[47:32], dst_port[63:48], payload_handle[79:64]
  input  logic [79:0]   s_axis_tdata_i,
  // fin_flag[0], ack_flag[1], checksum_ok[2]
  input  logic [2:0]    s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // ack_num[31:0], out_src_port[47:32], out_dst_port[63:48],
  // delivered_handle[79:64], delivered_seq[111:80]
  output logic [111:0]  m_axis_tdata_o,
  // kind[1:0]
  output logic [1:0]    m_axis_tuser_o,
  output logic          m_axis_tlast_o
);

  localparam int IdxW = $clog2(WINDOW_SLOTS);
  localparam int CntW = $clog2(WINDOW_SLOTS + 1);
  localparam logic [IdxW:0]   WinExt  = (IdxW + 1)'(WINDOW_SLOTS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(WINDOW_SLOTS - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(WINDOW_SLOTS);
  localparam logic [31:0]     Win32   = 32'(WINDOW_SLOTS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIFF  = 3'd1;
  localparam logic [2:0] ST_STORE = 3'd2;
  localparam logic [2:0] ST_FCHK  = 3'd3;
  localparam logic [2:0] ST_ACK   = 3'd4;
  localparam logic [2:0] ST_DLV   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;
  localparam logic [2:0] ST_CLOSE = 3'd7;

  logic [2:0]      state_q, state_d;
  logic [31:0]     seq_q;
  logic            fin_q, ack_q, ok_q;
  logic [15:0]     sport_q, dport_q, handle_q;
  logic [31:0]     expect_q, expect_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [1:0]      mode_q, mode_d;
  logic [31:0]     fin_seq_q, fin_seq_d;
  logic [IdxW-1:0] dist_q, dist_d;
  logic            win_q, win_d;
  logic [31:0]     ackn_q, ackn_d;
  logic            eq_q, eq_d;

  logic            out_valid_q;
  logic [1:0]      out_kind_q;
  logic [31:0]     out_ackn_q;
  logic [15:0]     out_src_q, out_dst_q, out_handle_q;
  logic [31:0]     out_dseq_q;
  logic            out_last_q;

  logic            load;
  logic [1:0]      ld_kind;
  logic [31:0]     ld_ackn;
  logic [15:0]     ld_src, ld_dst, ld_handle;
  logic [31:0]     ld_dseq;
  logic            ld_last;

  alu_req_t        alu_req;
  logic [31:0]     alu_sum;
  logic            alu_eq;

  logic                    wr_en, clr_en;
  logic [IdxW-1:0]         slot_idx, head_next;
  logic [IdxW:0]           slot_sum;
  logic [15:0]             rd_handle;
  logic [WINDOW_SLOTS-1:0] slot_valid;
  logic                    out_free, accept;
  logic                    more, fcond, nvalid, fcond_dlv;

  srr_alu u_alu (
    .req_i (alu_req),
    .sum_o (alu_sum),
    .eq_o  (alu_eq)
  );

  srr_slot_buf #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_slot_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_idx_i    (slot_idx),
    .wr_handle_i (handle_q),
    .clr_en_i    (clr_en),
    .clr_idx_i   (head_q),
    .rd_idx_i    (head_d),
    .rd_handle_o (rd_handle),
    .valid_o     (slot_valid)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // slot of the segment: position in the window relative to the head
  assign slot_sum  = {1'b0, head_q} + {1'b0, dist_q};
  assign slot_idx  = (slot_sum >= WinExt) ? IdxW'(slot_sum - WinExt) : slot_sum[IdxW-1:0];
  assign head_next = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);

  assign more      = !fin_q && slot_valid[head_q];
  assign fcond     = (mode_q == MODE_CLOSE_WAIT) && (fill_q == '0) && eq_q;
  assign nvalid    = slot_valid[head_next];
  assign fcond_dlv = (mode_q == MODE_CLOSE_WAIT) && (fill_q == CntW'(1)) && alu_eq;

  always_comb begin
    alu_req = '{a: expect_q, b: 32'd0, c: fin_seq_q, sub: 1'b0};
    unique case (state_q)
      ST_DIFF:  alu_req = '{a: seq_q, b: expect_q, c: fin_seq_q, sub: 1'b1};
      ST_STORE: alu_req = '{a: seq_q, b: 32'd1, c: fin_seq_q, sub: 1'b0};
      ST_DLV:   alu_req = '{a: expect_q, b: 32'd1, c: fin_seq_q, sub: 1'b0};
      ST_FIN:   alu_req = '{a: fin_seq_q, b: 32'd1, c: fin_seq_q, sub: 1'b0};
      default:  alu_req = '{a: expect_q, b: 32'd0, c: fin_seq_q, sub: 1'b0};
    endcase
  end

  always_comb begin
    state_d   = state_q;
    expect_d  = expect_q;
    fill_d    = fill_q;
    head_d    = head_q;
    mode_d    = mode_q;
    fin_seq_d = fin_seq_q;
    dist_d    = dist_q;
    win_d     = win_q;
    ackn_d    = ackn_q;
    eq_d      = eq_q;
    wr_en     = 1'b0;
    clr_en    = 1'b0;
    load      = 1'b0;
    ld_kind   = KIND_ACK;
    ld_ackn   = 32'd0;
    ld_src    = dport_q;
    ld_dst    = sport_q;
    ld_handle = 16'd0;
    ld_dseq   = 32'd0;
    ld_last   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        dist_d = alu_sum[IdxW-1:0];
        win_d  = (alu_sum < Win32);
        priority if (!ok_q || mode_q == MODE_CLOSED) begin
          state_d = ST_IDLE;
        end else if (ack_q && mode_q == MODE_LAST_ACK) begin
          state_d = ST_CLOSE;
        end else begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        ackn_d = alu_sum;
        if (fin_q) begin
          if (mode_q == MODE_ESTABLISHED) begin
            mode_d    = MODE_CLOSE_WAIT;
            fin_seq_d = seq_q;
          end
        end else if (win_q && !slot_valid[slot_idx] && fill_q < FullCnt) begin
          wr_en  = 1'b1;
          fill_d = fill_q + CntW'(1);
        end
        state_d = ST_FCHK;
      end
      ST_FCHK: begin
        eq_d    = alu_eq;
        state_d = ST_ACK;
      end
      ST_ACK: begin
        if (out_free) begin
          load    = 1'b1;
          ld_kind = KIND_ACK;
          ld_ackn = ackn_q;
          ld_last = !more && !fcond;
          priority if (more) begin
            state_d = ST_DLV;
          end else if (fcond) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DLV: begin
        if (out_free) begin
          load      = 1'b1;
          ld_kind   = KIND_DLV;
          ld_src    = 16'd0;
          ld_dst    = 16'd0;
          ld_handle = rd_handle;
          ld_dseq   = expect_q;
          ld_last   = !nvalid && !fcond_dlv;
          clr_en    = 1'b1;
          fill_d    = fill_q - CntW'(1);
          head_d    = head_next;
          expect_d  = alu_sum;
          priority if (nvalid) begin
            state_d = ST_DLV;
          end else if (fcond_dlv) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          load    = 1'b1;
          ld_kind = KIND_FIN;
          ld_ackn = alu_sum;
          mode_d  = MODE_LAST_ACK;
          state_d = ST_IDLE;
        end
      end
      ST_CLOSE: begin
        if (out_free) begin
          load    = 1'b1;
          ld_kind = KIND_CLOSE;
          mode_d  = MODE_CLOSED;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      expect_q    <= '0;
      fill_q      <= '0;
      head_q      <= '0;
      mode_q      <= MODE_ESTABLISHED;
      fin_seq_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      expect_q  <= expect_d;
      fill_q    <= fill_d;
      head_q    <= head_d;
      mode_q    <= mode_d;
      fin_seq_q <= fin_seq_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // segment fields and per-item scratch
  always_ff @(posedge clk_i) begin
    if (accept) begin
      seq_q    <= s_axis_tdata_i[31:0];
      sport_q  <= s_axis_tdata_i[47:32];
      dport_q  <= s_axis_tdata_i[63:48];
      handle_q <= s_axis_tdata_i[79:64];
      fin_q    <= s_axis_tuser_i[0];
      ack_q    <= s_axis_tuser_i[1];
      ok_q     <= s_axis_tuser_i[2];
    end
    dist_q <= dist_d;
    win_q  <= win_d;
    ackn_q <= ackn_d;
    eq_q   <= eq_d;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q   <= ld_kind;
      out_ackn_q   <= ld_ackn;
      out_src_q    <= ld_src;
      out_dst_q    <= ld_dst;
      out_handle_q <= ld_handle;
      out_dseq_q   <= ld_dseq;
      out_last_q   <= ld_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_dseq_q, out_handle_q, out_dst_q, out_src_q, out_ackn_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // fill count tracks the number of occupied slots
  `SRR_ASSERT(a_fill_matches, 32'(fill_q) == $countones(slot_valid), "fill count mismatch")
  // the in-order run is always fully drained before the next segment
  `SRR_ASSERT(a_head_drained, (state_q != ST_IDLE) || !slot_valid[head_q], "head slot left full")
  // a closed connection never reopens
  `SRR_ASSERT_NXT(a_closed_sticky, mode_q == MODE_CLOSED, mode_q == MODE_CLOSED, "left closed")
  // fin and close results always end their item
  `SRR_ASSERT(a_fin_last,
    !out_valid_q || out_kind_q == KIND_ACK || out_kind_q == KIND_DLV || out_last_q,
    "fin or close result without last")

endmodule

/* rtl/srr_alu.sv */
// shared 32-bit add/subtract unit with equality compare on the sum
// depends on srr_pkg
module srr_alu import srr_pkg::*; (
  input  alu_req_t    req_i,
  output logic [31:0] sum_o,
  output logic        eq_o
);

  logic [31:0] b_eff;

  assign b_eff = req_i.sub ? ~req_i.b : req_i.b;
  assign sum_o = req_i.a + b_eff + {31'b0, req_i.sub};
  assign eq_o  = (sum_o == req_i.c);

endmodule

/* rtl/srr_slot_buf.sv */
// reorder window storage: per-slot valid flops and a handle memory
// registered read port; depends on srr_pkg
module srr_slot_buf import srr_pkg::*; #(
  parameter int WINDOW_SLOTS = WindowSlotsDefault,
  localparam int IdxW = $clog2(WINDOW_SLOTS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [IdxW-1:0]         wr_idx_i,
  input  logic [15:0]             wr_handle_i,
  input  logic                    clr_en_i,
  input  logic [IdxW-1:0]         clr_idx_i,
  input  logic [IdxW-1:0]         rd_idx_i,
  output logic [15:0]             rd_handle_o,
  output logic [WINDOW_SLOTS-1:0] valid_o
);

  logic [15:0]             mem [WINDOW_SLOTS];
  logic [WINDOW_SLOTS-1:0] valid_q;
  logic [15:0]             rd_handle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (clr_en_i) begin
        valid_q[clr_idx_i] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_handle_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_handle_q <= mem[rd_idx_i];
  end

  assign rd_handle_o = rd_handle_q;
  assign valid_o     = valid_q;

endmodule

/* tb/segment_reorder_receiver_core_test.sv */
// self-checking testbench for segment_reorder_receiver_core: random segment streams
// with bursty input and stalling output, checked against a built-in window predictor
// depends on srr_pkg and the core rtl only
module segment_reorder_receiver_core_test;
  import srr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN        = WindowSlotsDefault;
  localparam int N_RANDOM   = 330;
  localparam int CYCLE_CAP  = 500000;
  localparam int HOLDOFF    = 400;
  localparam int TAIL       = 40;
  localparam int MAX_REPORT = 10;

  typedef struct packed {
    logic [31:0] seq;
    logic        fin;
    logic        ack;
    logic        ok;
    logic [15:0] src;
    logic [15:0] dst;
    logic [15:0] handle;
  } seg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] ack_num;
    logic [15:0] osrc;
    logic [15:0] odst;
    logic [15:0] dhandle;
    logic [31:0] dseq;
    logic        last;
  } reply_t;

  // receive window predictor plus the queue of replies it expects
  class seg_scoreboard;
    logic [31:0] exp_seq;
    logic [31:0] fin_seq;
    logic [1:0]  mode;
    int          filled;
    int          head;
    bit          valid [WIN];
    logic [15:0] handles [WIN];
    reply_t      replies_due [$];
    int          errors;
    int          n_segs;
    int          n_results;
    int          n_dlv;
    int          most_per_seg;

    function new();
      exp_seq = '0;
      fin_seq = '0;
      mode = MODE_ESTABLISHED;
      filled = 0;
      head = 0;
      foreach (valid[i]) valid[i] = 1'b0;
      errors = 0;
      n_segs = 0;
      n_results = 0;
      n_dlv = 0;
      most_per_seg = 0;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function void push_reply(logic [1:0] k, logic [31:0] a, logic [15:0] sp, logic [15:0] dp,
                             logic [15:0] h, logic [31:0] sq);
      reply_t r;
      r.kind = k;
      r.ack_num = a;
      r.osrc = sp;
      r.odst = dp;
      r.dhandle = h;
      r.dseq = sq;
      r.last = 1'b0;
      replies_due.push_back(r);
      if (k == KIND_DLV) n_dlv++;
    endfunction

    function void note_segment(seg_t s);
      logic [31:0] d;
      int          slot;
      int          first;
      reply_t      r;
      n_segs++;
      if (!s.ok || mode == MODE_CLOSED) return;
      first = replies_due.size();
      if (s.ack && mode == MODE_LAST_ACK) begin
        mode = MODE_CLOSED;
        push_reply(KIND_CLOSE, '0, s.dst, s.src, '0, '0);
      end else begin
        push_reply(KIND_ACK, s.seq + 32'd1, s.dst, s.src, '0, '0);
        if (s.fin) begin
          if (mode == MODE_ESTABLISHED) begin
            mode = MODE_CLOSE_WAIT;
            fin_seq = s.seq;
          end
        end else begin
          d = s.seq - exp_seq;
          if (d < WIN) begin
            slot = (head + int'(d)) % WIN;
            // first handle in a slot wins
            if (!valid[slot] && filled < WIN) begin
              valid[slot] = 1'b1;
              handles[slot] = s.handle;
              filled++;
            end
          end
          while (valid[head]) begin
            push_reply(KIND_DLV, '0, '0, '0, handles[head], exp_seq);
            valid[head] = 1'b0;
            if (filled > 0) filled--;
            head = (head + 1) % WIN;
            exp_seq = exp_seq + 32'd1;
          end
        end
        if (mode == MODE_CLOSE_WAIT && filled == 0 && exp_seq == fin_seq) begin
          push_reply(KIND_FIN, fin_seq + 32'd1, s.dst, s.src, '0, '0);
          mode = MODE_LAST_ACK;
        end
      end
      r = replies_due.pop_back();
      r.last = 1'b1;
      replies_due.push_back(r);
      if (replies_due.size() - first > most_per_seg) most_per_seg = replies_due.size() - first;
    endfunction

    function void check_result(logic [111:0] d, logic [1:0] k, logic l);
      reply_t got;
      reply_t want;
      got.kind = k;
      got.ack_num = d[31:0];
      got.osrc = d[47:32];
      got.odst = d[63:48];
      got.dhandle = d[79:64];
      got.dseq = d[111:80];
      got.last = l;
      n_results++;
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORT)
          $display("%0t: result with nothing expected: kind %0d ack %h ports %h/%h handle %h seq %h last %b",
                   $realtime, got.kind, got.ack_num, got.osrc, got.odst, got.dhandle, got.dseq,
                   got.last);
        return;
      end
      want = replies_due.pop_front();
      if (got != want) begin
        errors++;
        if (errors <= MAX_REPORT) begin
          $display("%0t: mismatch, expected kind %0d ack %h ports %h/%h handle %h seq %h last %b",
                   $realtime, want.kind, want.ack_num, want.osrc, want.odst, want.dhandle,
                   want.dseq, want.last);
          $display("%0t:           got      kind %0d ack %h ports %h/%h handle %h seq %h last %b",
                   $realtime, got.kind, got.ack_num, got.osrc, got.odst, got.dhandle, got.dseq,
                   got.last);
        end
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  // seq_num[31:0], src_port[47:32], dst_port[63:48], payload_handle[79:64]
  logic [79:0]  s_axis_tdata_i = '0;
  // fin_flag[0], ack_flag[1], checksum_ok[2]
  logic [2:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  // ack_num[31:0], out_src_port[47:32], out_dst_port[63:48],
  // delivered_handle[79:64], delivered_seq[111:80]
  logic [111:0] m_axis_tdata_o;
  // kind[1:0]
  logic [1:0]   m_axis_tuser_o;
  logic         m_axis_tlast_o;

  seg_scoreboard sb = new();
  bit            hold_req = 1'b0;
  int            burst_left = 0;
  int            cycles = 0;

  segment_reorder_receiver_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycles, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
  end

  // output side: random stall patterns held for random spans, one long holdoff
  initial begin
    int  pat = 0;
    int  span = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLDOFF;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        if (span == 0) begin
          pat = $urandom_range(0, 3);
          span = $urandom_range(20, 200);
        end
        span--;
        case (pat)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready_i <= ~m_axis_tready_i;
        endcase
      end
    end
  end

  function automatic seg_t mk_seg(logic [31:0] sq, logic f, logic a, logic ok,
                                  logic [15:0] sp, logic [15:0] dp, logic [15:0] h);
    seg_t s;
    s.seq = sq;
    s.fin = f;
    s.ack = a;
    s.ok = ok;
    s.src = sp;
    s.dst = dp;
    s.handle = h;
    return s;
  endfunction

  // ordinary good data segment with random ports, handle and ack flag
  function automatic seg_t data_seg(logic [31:0] sq);
    return mk_seg(sq, 1'b0, 1'($urandom), 1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  function automatic seg_t rand_seg();
    int   pick;
    int   off;
    seg_t s;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      // mostly small offsets so the in-order run keeps moving
      off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, WIN - 1) : $urandom_range(0, 4);
      s = data_seg(sb.exp_seq + 32'(off));
    end else if (pick < 75) begin
      s = data_seg(sb.exp_seq - 32'($urandom_range(1, 40)));
    end else if (pick < 83) begin
      if ($urandom_range(0, 1) == 0) s = data_seg(sb.exp_seq + 32'(WIN + $urandom_range(0, 100)));
      else s = data_seg($urandom);
    end else begin
      s = mk_seg($urandom, 1'($urandom), 1'($urandom), 1'b0, 16'($urandom), 16'($urandom),
                 16'($urandom));
    end
    return s;
  endfunction

  // offer one segment until taken, then maybe end the burst with a gap
  task automatic send_seg(input seg_t s);
    int gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {s.handle, s.dst, s.src, s.seq};
    s_axis_tuser_i <= {s.ok, s.ack, s.fin};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_segment(s);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() > 0);
  endtask

  initial begin
    logic [31:0] base;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // in order, out of order, duplicate slot, retransmit, outside window, wraps, bad checksum
    send_seg(mk_seg(32'd0, 1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000));
    send_seg(mk_seg(32'd2, 1'b0, 1'b0, 1'b1, 16'hffff, 16'hffff, 16'hffff));
    send_seg(mk_seg(32'd2, 1'b0, 1'b0, 1'b1, 16'h1234, 16'h4321, 16'h0bad));
    send_seg(mk_seg(32'd1, 1'b0, 1'b1, 1'b1, 16'h00ff, 16'hff00, 16'h5a5a));
    send_seg(data_seg(32'd0));
    send_seg(data_seg(sb.exp_seq + 32'(WIN)));
    send_seg(data_seg(32'hffff_ffff));
    send_seg(mk_seg(32'hffff_ffff, 1'b1, 1'b1, 1'b0, 16'hffff, 16'hffff, 16'hffff));
    send_seg(data_seg(sb.exp_seq + 32'(WIN - 1)));
    send_seg(data_seg(sb.exp_seq + 32'd1));
    send_seg(data_seg(sb.exp_seq));
    send_seg(data_seg(32'h8000_0000));

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) hold_req = 1'b1;
      if (i == 2 * N_RANDOM / 3) wait_drained();
      send_seg(rand_seg());
    end

    // close sequence: empty the window, park a fin one window ahead, then fill backwards
    while (sb.filled > 0) send_seg(data_seg(sb.exp_seq));
    base = sb.exp_seq;
    send_seg(mk_seg(base + 32'(WIN), 1'b1, 1'b1, 1'b1, 16'($urandom), 16'($urandom),
                    16'($urandom)));
    for (int off = WIN - 1; off >= 1; off--) begin
      send_seg(data_seg(base + 32'(off)));
      if (off == WIN / 2) begin
        // second fin while in close wait is only acked
        send_seg(mk_seg($urandom, 1'b1, 1'b0, 1'b1, 16'($urandom), 16'($urandom), 16'($urandom)));
        send_seg(data_seg(base + 32'(off)));
      end
    end
    // completes the run: ack, full window of deliveries and the fin
    send_seg(data_seg(base));
    // last ack: data and fin without ack flag still handled, bad checksum dropped
    send_seg(mk_seg(sb.exp_seq, 1'b0, 1'b0, 1'b1, 16'($urandom), 16'($urandom), 16'($urandom)));
    send_seg(mk_seg($urandom, 1'b1, 1'b0, 1'b1, 16'($urandom), 16'($urandom), 16'($urandom)));
    send_seg(mk_seg($urandom, 1'b0, 1'b1, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom)));
    send_seg(mk_seg($urandom, 1'b0, 1'b1, 1'b1, 16'($urandom), 16'($urandom), 16'($urandom)));
    // closed: everything ignored
    for (int i = 0; i < 3; i++) send_seg(data_seg(sb.exp_seq));

    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    $display("run covered %0d segments and %0d checked replies, %0d of them deliveries",
             sb.n_segs, sb.n_results, sb.n_dlv);
    $display("up to %0d replies for one segment, connection taken through fin to closed",
             sb.most_per_seg);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
